FILE: hdl/kfs_pkg.sv
// ----------------------------------------------------------------------------
// kfs_pkg: shared types, codes and microcode for the Kalman filter step
// Payload structs, sequencer states, operand codes, scratch slots and the
// microcode store that drives the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kfs_pkg;

   typedef struct packed {
      logic               func;
      logic signed [31:0] measurement;
   } kfs_req_type;

   typedef struct packed {
      logic signed [31:0] estimate_first;
      logic signed [31:0] estimate_second;
      logic signed [31:0] variance_first;
      logic signed [31:0] variance_second;
      logic               gain_fault;
   } kfs_rsp_type;

   typedef enum logic [2:0] {
      CSR_TRANSITION  = 3'd0,
      CSR_MEASUREMENT = 3'd1,
      CSR_PROC_NOISE  = 3'd2,
      CSR_MEAS_NOISE  = 3'd3,
      CSR_INIT_STATE  = 3'd4,
      CSR_INIT_COV    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_ACCUM,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      UOP_MAC,
      UOP_DIV,
      UOP_JUMP,
      UOP_STOP
   } uop_kind_type;

   typedef enum logic [1:0] {
      SHIFT_0,
      SHIFT_8,
      SHIFT_16
   } shift_type;

   typedef struct packed {
      uop_kind_type kind;
      logic         first;
      logic         last;
      logic         neg;
      logic [5:0]   src_a;
      logic [5:0]   src_b;
      shift_type    shift;
      logic [4:0]   dest;
   } uop_type;

   typedef struct packed {
      logic      prod_en;
      logic      acc_en;
      logic      first;
      logic      neg;
      shift_type shift;
   } mac_ctrl_type;

   // scratch slots
   localparam logic [5:0] SLOT_X0  = 6'd0;
   localparam logic [5:0] SLOT_X1  = 6'd1;
   localparam logic [5:0] SLOT_P0  = 6'd2;
   localparam logic [5:0] SLOT_P3  = 6'd5;
   localparam logic [5:0] SLOT_XP  = 6'd6;
   localparam logic [5:0] SLOT_PP  = 6'd8;
   localparam logic [5:0] SLOT_Q   = 6'd12;
   localparam logic [5:0] SLOT_M   = 6'd16;
   localparam logic [5:0] SLOT_PHT = 6'd20;
   localparam logic [5:0] SLOT_S   = 6'd22;
   localparam logic [5:0] SLOT_KG  = 6'd23;
   localparam logic [5:0] SLOT_HX  = 6'd25;
   localparam logic [5:0] SLOT_Y   = 6'd26;
   localparam logic [5:0] SLOT_KR  = 6'd25;
   localparam logic [5:0] SLOT_A   = 6'd27;

   // external operands
   localparam logic [5:0] SRC_F0    = 6'd32;
   localparam logic [5:0] SRC_F1    = 6'd33;
   localparam logic [5:0] SRC_F2    = 6'd34;
   localparam logic [5:0] SRC_F3    = 6'd35;
   localparam logic [5:0] SRC_H0    = 6'd36;
   localparam logic [5:0] SRC_H1    = 6'd37;
   localparam logic [5:0] SRC_QA0   = 6'd38;
   localparam logic [5:0] SRC_QA1   = 6'd39;
   localparam logic [5:0] SRC_QA2   = 6'd40;
   localparam logic [5:0] SRC_QA3   = 6'd41;
   localparam logic [5:0] SRC_IC0   = 6'd42;
   localparam logic [5:0] SRC_IC1   = 6'd43;
   localparam logic [5:0] SRC_IC2   = 6'd44;
   localparam logic [5:0] SRC_IC3   = 6'd45;
   localparam logic [5:0] SRC_IS0   = 6'd46;
   localparam logic [5:0] SRC_IS1   = 6'd47;
   localparam logic [5:0] SRC_Z     = 6'd48;
   localparam logic [5:0] SRC_R     = 6'd49;
   localparam logic [5:0] SRC_ONE   = 6'd50;
   localparam logic [5:0] SRC_256   = 6'd51;
   localparam logic [5:0] SRC_65536 = 6'd52;

   localparam int         ROM_DEPTH     = 97;
   localparam logic [6:0] RESTART_START = 7'd0;
   localparam logic [6:0] UPDATE_START  = 7'd27;
   localparam logic [6:0] PREDICT_START = 7'd72;

   typedef uop_type [ROM_DEPTH-1:0] rom_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic uop_type mac_uop(input logic first, input logic last,
                                       input logic neg, input int a, input int b,
                                       input shift_type sh, input int d);
      uop_type u;
      u.kind  = UOP_MAC;
      u.first = first;
      u.last  = last;
      u.neg   = neg;
      u.src_a = 6'(a);
      u.src_b = 6'(b);
      u.shift = sh;
      u.dest  = 5'(d);
      return u;
   endfunction

   function automatic uop_type ctl_uop(input uop_kind_type kind, input int a,
                                       input int b, input int d);
      uop_type u;
      u       = mac_uop(1'b1, 1'b1, 1'b0, a, b, SHIFT_0, d);
      u.kind  = kind;
      return u;
   endfunction

   function automatic rom_type build_rom();
      rom_type rom;
      int      n;
      n   = 0;
      rom = '0;
      // restart: scaled noise, initial covariance and state
      for (int i = 0; i < 4; i++) begin
         rom[n] = mac_uop(1'b1, 1'b1, 1'b0, SRC_QA0 + i, SRC_256, SHIFT_0, SLOT_A + i);
         n++;
      end
      for (int i = 0; i < 4; i++) begin
         rom[n] = mac_uop(1'b1, 1'b1, 1'b0, SRC_IC0 + i, SRC_256, SHIFT_0, SLOT_P0 + i);
         n++;
      end
      for (int i = 0; i < 2; i++) begin
         rom[n] = mac_uop(1'b1, 1'b1, 1'b0, SRC_IS0 + i, SRC_ONE, SHIFT_0, SLOT_X0 + i);
         n++;
      end
      // Q = F Qa F'
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++) begin
               rom[n] = mac_uop(k == 0, k == 1, 1'b0, SRC_F0 + i * 2 + k,
                                SLOT_A + k * 2 + j, SHIFT_8, SLOT_M + i * 2 + j);
               n++;
            end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++) begin
               rom[n] = mac_uop(k == 0, k == 1, 1'b0, SLOT_M + i * 2 + k,
                                SRC_F0 + j * 2 + k, SHIFT_8, SLOT_Q + i * 2 + j);
               n++;
            end
      rom[n] = ctl_uop(UOP_JUMP, 0, 0, 0);
      n++;
      // update: P H'
      for (int i = 0; i < 2; i++)
         for (int k = 0; k < 2; k++) begin
            rom[n] = mac_uop(k == 0, k == 1, 1'b0, SLOT_PP + i * 2 + k, SRC_H0 + k,
                             SHIFT_8, SLOT_PHT + i);
            n++;
         end
      rom[n] = mac_uop(1'b1, 1'b0, 1'b0, SRC_R, SRC_256, SHIFT_0, SLOT_S);
      n++;
      for (int k = 0; k < 2; k++) begin
         rom[n] = mac_uop(1'b0, k == 1, 1'b0, SRC_H0 + k, SLOT_PHT + k, SHIFT_8, SLOT_S);
         n++;
      end
      for (int i = 0; i < 2; i++) begin
         rom[n] = ctl_uop(UOP_DIV, SLOT_PHT + i, SLOT_S, SLOT_KG + i);
         n++;
      end
      for (int k = 0; k < 2; k++) begin
         rom[n] = mac_uop(k == 0, k == 1, 1'b0, SRC_H0 + k, SLOT_XP + k, SHIFT_8, SLOT_HX);
         n++;
      end
      rom[n] = mac_uop(1'b1, 1'b0, 1'b0, SRC_Z, SRC_ONE, SHIFT_0, SLOT_Y);
      n++;
      rom[n] = mac_uop(1'b0, 1'b1, 1'b1, SLOT_HX, SRC_ONE, SHIFT_0, SLOT_Y);
      n++;
      for (int i = 0; i < 2; i++) begin
         rom[n] = mac_uop(1'b1, 1'b0, 1'b0, SLOT_XP + i, SRC_ONE, SHIFT_0, SLOT_X0 + i);
         n++;
         rom[n] = mac_uop(1'b0, 1'b1, 1'b0, SLOT_KG + i, SLOT_Y, SHIFT_16, SLOT_X0 + i);
         n++;
      end
      // A = I - K H
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            if (i == j) begin
               rom[n] = mac_uop(1'b1, 1'b0, 1'b0, SRC_ONE, SRC_65536, SHIFT_0,
                                SLOT_A + i * 2 + j);
               n++;
            end
            rom[n] = mac_uop(i != j, 1'b1, 1'b1, SLOT_KG + i, SRC_H0 + j, SHIFT_8,
                             SLOT_A + i * 2 + j);
            n++;
         end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++) begin
               rom[n] = mac_uop(k == 0, k == 1, 1'b0, SLOT_A + i * 2 + k,
                                SLOT_PP + k * 2 + j, SHIFT_16, SLOT_M + i * 2 + j);
               n++;
            end
      for (int i = 0; i < 2; i++) begin
         rom[n] = mac_uop(1'b1, 1'b1, 1'b0, SLOT_KG + i, SRC_R, SHIFT_8, SLOT_KR + i);
         n++;
      end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            rom[n] = mac_uop(1'b1, 1'b0, 1'b0, SLOT_KR + i, SLOT_KG + j, SHIFT_16,
                             SLOT_P0 + i * 2 + j);
            n++;
            for (int k = 0; k < 2; k++) begin
               rom[n] = mac_uop(1'b0, k == 1, 1'b0, SLOT_M + i * 2 + k,
                                SLOT_A + j * 2 + k, SHIFT_16, SLOT_P0 + i * 2 + j);
               n++;
            end
         end
      // predict
      for (int i = 0; i < 2; i++)
         for (int k = 0; k < 2; k++) begin
            rom[n] = mac_uop(k == 0, k == 1, 1'b0, SRC_F0 + i * 2 + k, SLOT_X0 + k,
                             SHIFT_8, SLOT_XP + i);
            n++;
         end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++) begin
               rom[n] = mac_uop(k == 0, k == 1, 1'b0, SRC_F0 + i * 2 + k,
                                SLOT_P0 + k * 2 + j, SHIFT_8, SLOT_M + i * 2 + j);
               n++;
            end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            rom[n] = mac_uop(1'b1, 1'b0, 1'b0, SLOT_Q + i * 2 + j, SRC_ONE, SHIFT_0,
                             SLOT_PP + i * 2 + j);
            n++;
            for (int k = 0; k < 2; k++) begin
               rom[n] = mac_uop(1'b0, k == 1, 1'b0, SLOT_M + i * 2 + k,
                                SRC_F0 + j * 2 + k, SHIFT_8, SLOT_PP + i * 2 + j);
               n++;
            end
         end
      rom[n] = ctl_uop(UOP_STOP, 0, 0, 0);
      return rom;
   endfunction

   localparam rom_type UCODE = build_rom();

endpackage

`default_nettype wire

FILE: hdl/kfs_regfile.sv
// ----------------------------------------------------------------------------
// kfs_regfile: scratch store for filter operands
// One write port, two registered read ports; entries read as zero until
// written after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kfs_regfile
   import kfs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [4:0]         wr_addr,
   input  wire logic signed [31:0] wr_data,
   input  wire logic [4:0]         rd_addr_a,
   input  wire logic [4:0]         rd_addr_b,
   output logic signed [31:0]      rd_data_a,
   output logic signed [31:0]      rd_data_b
);

   logic signed [31:0] mem [32];
   logic [31:0]        valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= valid_ff[rd_addr_a] ? mem[rd_addr_a] : '0;
      rd_data_b <= valid_ff[rd_addr_b] ? mem[rd_addr_b] : '0;
   end

endmodule

`default_nettype wire

FILE: hdl/kfs_mac.sv
// ----------------------------------------------------------------------------
// kfs_mac: shared multiply-accumulate unit
// Registered 32x32 signed product, floored shift, signed accumulate and
// saturation of the running sum to the Q16.16 range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kfs_mac
   import kfs_pkg::*;
(
   input  wire logic               clock,
   input  wire mac_ctrl_type       ctrl,
   input  wire logic signed [31:0] op_a,
   input  wire logic signed [31:0] op_b,
   output logic signed [31:0]      acc_sat
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] acc_in;
   logic signed [63:0] term;
   logic signed [63:0] base;

   always_comb begin
      case (ctrl.shift)
         SHIFT_8:  term = prod_ff >>> 8;
         SHIFT_16: term = prod_ff >>> 16;
         default:  term = prod_ff;
      endcase
      base    = ctrl.first ? 64'sd0 : acc_ff;
      acc_in  = ctrl.neg ? base - term : base + term;
      acc_sat = sat32(acc_in);
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= op_a * op_b;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/kfs_divider.sv
// ----------------------------------------------------------------------------
// kfs_divider: gain divider
// Restoring division of num * 2^16 by den, one quotient bit a cycle,
// truncated toward zero and saturated to Q16.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kfs_divider
   import kfs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic                    done,
   output logic signed [31:0]      quotient
);

   localparam int QUO_W = 48;
   localparam int CNT_W = $clog2(QUO_W);

   logic [31:0]      rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [31:0]      dmag_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [32:0]      shifted;
   logic [32:0]      diff;
   logic             ge;
   logic [31:0]      num_mag, den_mag;
   logic signed [63:0] q_signed;

   always_comb begin
      num_mag = num[31] ? 32'(-num) : num;
      den_mag = den[31] ? 32'(-den) : den;
      shifted = {rem_ff, quo_ff[QUO_W-1]};
      ge      = shifted >= {1'b0, dmag_ff};
      diff    = shifted - {1'b0, dmag_ff};
      rem_in  = ge ? diff[31:0] : shifted[31:0];
      quo_in  = {quo_ff[QUO_W-2:0], ge};
      q_signed = neg_ff ? -$signed({16'd0, quo_ff}) : $signed({16'd0, quo_ff});
      quotient = sat32(q_signed);
      done     = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quo_ff  <= {num_mag, 16'd0};
         dmag_ff <= den_mag;
         neg_ff  <= num[31] ^ den[31];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/kalman_filter_step.sv
// ----------------------------------------------------------------------------
// kalman_filter_step: two-state, one-measurement Kalman filter step
// Microcoded sequencer over one shared multiply-accumulate unit and one
// bit-serial divider; Joseph-form covariance update and prediction.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  kfs_req_type (func, measurement)
//  rsp_      out        rsp_valid/rsp_stall  kfs_rsp_type (estimates, variances, fault)
//  csr_      in         csr_write            csr_index, csr_wdata
//
//  Each product term passes through fetch, multiply and accumulate on the
//  single multiplier; each gain division is started and then waits for the
//  divider, but when the innovation variance is zero the divider is skipped
//  and the gain is written as zero.
//  Reset clears the operand store valid bits; state reads as zero.
//  req_stall is high while an item is in work; a waiting result holds the
//  next item only at its last cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kalman_filter_step
   import kfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire kfs_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output kfs_rsp_type      rsp_data,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   state_type   state_ff, state_in;
   logic [6:0]  pc_ff, pc_in;
   uop_type     uop;
   logic [63:0] f_ff, qa_ff, is_ff, ic_ff;
   logic [31:0] h_ff;
   logic [15:0] r_ff;
   logic signed [31:0] z_ff;
   logic        fault_ff;
   logic        rsp_valid_ff;
   kfs_rsp_type rsp_ff, stage_ff;

   logic               wr_en;
   logic signed [31:0] wr_data;
   logic signed [31:0] rd_a, rd_b, op_a, op_b, acc_sat, div_q;
   logic               div_start, div_done;
   logic               accept, finish_go;
   mac_ctrl_type       mac_ctrl;

   assign uop       = UCODE[pc_ff];
   assign accept    = req_valid && !req_stall;
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic logic signed [31:0] operand(input logic [5:0] src,
                                                  input logic signed [31:0] mem);
      logic signed [31:0] v;
      case (src)
         SRC_F0:    v = 32'(signed'(f_ff[15:0]));
         SRC_F1:    v = 32'(signed'(f_ff[31:16]));
         SRC_F2:    v = 32'(signed'(f_ff[47:32]));
         SRC_F3:    v = 32'(signed'(f_ff[63:48]));
         SRC_H0:    v = 32'(signed'(h_ff[15:0]));
         SRC_H1:    v = 32'(signed'(h_ff[31:16]));
         SRC_QA0:   v = 32'(signed'(qa_ff[15:0]));
         SRC_QA1:   v = 32'(signed'(qa_ff[31:16]));
         SRC_QA2:   v = 32'(signed'(qa_ff[47:32]));
         SRC_QA3:   v = 32'(signed'(qa_ff[63:48]));
         SRC_IC0:   v = 32'(signed'(ic_ff[15:0]));
         SRC_IC1:   v = 32'(signed'(ic_ff[31:16]));
         SRC_IC2:   v = 32'(signed'(ic_ff[47:32]));
         SRC_IC3:   v = 32'(signed'(ic_ff[63:48]));
         SRC_IS0:   v = is_ff[31:0];
         SRC_IS1:   v = is_ff[63:32];
         SRC_Z:     v = z_ff;
         SRC_R:     v = {16'd0, r_ff};
         SRC_ONE:   v = 32'sd1;
         SRC_256:   v = 32'sd256;
         SRC_65536: v = 32'sd65536;
         default:   v = mem;
      endcase
      return v;
   endfunction

   always_comb begin
      op_a = operand(uop.src_a, rd_a);
      op_b = operand(uop.src_b, rd_b);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_FETCH;
         ST_FETCH: begin
            unique case (uop.kind)
               UOP_JUMP: state_in = ST_FETCH;
               UOP_STOP: state_in = ST_FINISH;
               default:  state_in = ST_EXEC;
            endcase
         end
         ST_EXEC: begin
            if (uop.kind == UOP_MAC) begin
               state_in = ST_ACCUM;
            end else begin
               state_in = fault_ff ? ST_FETCH : ST_DIVIDE;
            end
         end
         ST_ACCUM:  state_in = ST_FETCH;
         ST_DIVIDE: if (div_done) state_in = ST_FETCH;
         ST_FINISH: if (finish_go) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pc_in            = pc_ff;
      wr_en            = 1'b0;
      wr_data          = acc_sat;
      div_start        = 1'b0;
      mac_ctrl.prod_en = 1'b0;
      mac_ctrl.acc_en  = 1'b0;
      mac_ctrl.first   = uop.first;
      mac_ctrl.neg     = uop.neg;
      mac_ctrl.shift   = uop.shift;
      unique case (state_ff)
         ST_IDLE:  pc_in = req_data.func ? UPDATE_START : RESTART_START;
         ST_FETCH: if (uop.kind == UOP_JUMP) pc_in = PREDICT_START;
         ST_EXEC: begin
            if (uop.kind == UOP_MAC) begin
               mac_ctrl.prod_en = 1'b1;
            end else if (fault_ff) begin
               wr_en   = 1'b1;
               wr_data = '0;
               pc_in   = pc_ff + 7'd1;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_ACCUM: begin
            mac_ctrl.acc_en = 1'b1;
            wr_en           = uop.last;
            pc_in           = pc_ff + 7'd1;
         end
         ST_DIVIDE: begin
            wr_data = div_q;
            if (div_done) begin
               wr_en = 1'b1;
               pc_in = pc_ff + 7'd1;
            end
         end
         ST_FINISH: pc_in = pc_ff;
         default:   pc_in = pc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         fault_ff     <= 1'b0;
         f_ff         <= 64'h0100_0000_0000_0100;
         h_ff         <= 32'h0000_0100;
         qa_ff        <= '0;
         r_ff         <= 16'h0100;
         is_ff        <= '0;
         ic_ff        <= 64'h0100_0000_0000_0100;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            fault_ff <= 1'b0;
         end else if (state_ff == ST_ACCUM && uop.last && {1'b0, uop.dest} == SLOT_S
                      && acc_sat == 32'sd0) begin
            fault_ff <= 1'b1;
         end
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_TRANSITION:  f_ff  <= csr_wdata;
               CSR_MEASUREMENT: h_ff  <= csr_wdata[31:0];
               CSR_PROC_NOISE:  qa_ff <= csr_wdata;
               CSR_MEAS_NOISE:  r_ff  <= csr_wdata[15:0];
               CSR_INIT_STATE:  is_ff <= csr_wdata;
               CSR_INIT_COV:    ic_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         z_ff <= req_data.measurement;
      end
      if (wr_en) begin
         case ({1'b0, uop.dest})
            SLOT_X0: stage_ff.estimate_first  <= wr_data;
            SLOT_X1: stage_ff.estimate_second <= wr_data;
            SLOT_P0: stage_ff.variance_first  <= wr_data;
            SLOT_P3: stage_ff.variance_second <= wr_data;
            default: ;
         endcase
      end
      stage_ff.gain_fault <= fault_ff;
      if (finish_go) begin
         rsp_ff <= stage_ff;
      end
   end

   kfs_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (uop.dest),
      .wr_data   (wr_data),
      .rd_addr_a (uop.src_a[4:0]),
      .rd_addr_b (uop.src_b[4:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   kfs_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .op_a    (op_a),
      .op_b    (op_b),
      .acc_sat (acc_sat)
   );

   kfs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (op_a),
      .den      (op_b),
      .done     (div_done),
      .quotient (div_q)
   );

endmodule

`default_nettype wire

FILE: tb/kalman_filter_step_tb.sv
// ----------------------------------------------------------------------------
// kalman_filter_step_tb: self-checking bench for the Kalman filter step
// Drives restart and update transfers through a queue-fed driver, predicts
// each result with a fixed-point filter model kept in the bench, and checks
// every result transfer field by field. Configuration is rewritten between
// phases while the block is idle; idling and stalling vary per phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kalman_filter_step_tb;
   import kfs_pkg::*;

   localparam logic FUNC_RESTART = 1'b0;
   localparam logic FUNC_UPDATE  = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   kfs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   kfs_rsp_type rsp_data;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   kalman_filter_step u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // filter model state and registers
   logic [63:0]     mdl_f, mdl_qa, mdl_x0, mdl_p0;
   logic [31:0]     mdl_h;
   logic [15:0]     mdl_r;
   longint          xpred[2];
   longint          ppred[4];
   longint          qnoise[4];

   kfs_req_type     pending_req[$];
   kfs_rsp_type     expected_rsp[$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   bit              driving = 1'b0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint q88_entry(logic [63:0] reg_val, int k);
      logic signed [15:0] e;
      e = reg_val[16*k +: 16];
      return longint'(e);
   endfunction

   function automatic void fpft_model(longint p[4], longint add[4], output longint res[4]);
      longint f[4], m[4], acc;
      for (int i = 0; i < 4; i++) f[i] = q88_entry(mdl_f, i);
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            acc = 0;
            for (int k = 0; k < 2; k++) acc += floor_shift(f[i*2+k] * p[k*2+j], 8);
            m[i*2+j] = clamp32(acc);
         end
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++) begin
            acc = add[i*2+j];
            for (int k = 0; k < 2; k++) acc += floor_shift(m[i*2+k] * f[j*2+k], 8);
            res[i*2+j] = clamp32(acc);
         end
   endfunction

   function automatic kfs_rsp_type filter_step(kfs_req_type it);
      longint x[2], p[4], qa[4], zero[4], h[2], pht[2], kg[2], kr[2], a[4], m[4];
      longint r, z, s, hx, y, acc;
      logic signed [31:0] w;
      logic fault;
      kfs_rsp_type res;
      fault = 1'b0;
      if (it.func == FUNC_RESTART) begin
         for (int i = 0; i < 4; i++) begin
            qa[i] = q88_entry(mdl_qa, i) * 256;
            p[i] = q88_entry(mdl_p0, i) * 256;
            zero[i] = 0;
         end
         fpft_model(qa, zero, qnoise);
         for (int i = 0; i < 2; i++) begin
            w = mdl_x0[32*i +: 32];
            x[i] = longint'(w);
         end
      end else begin
         r = longint'({48'd0, mdl_r});
         z = longint'(it.measurement);
         for (int i = 0; i < 2; i++) h[i] = q88_entry({32'd0, mdl_h}, i);
         for (int i = 0; i < 2; i++) begin
            acc = 0;
            for (int k = 0; k < 2; k++) acc += floor_shift(ppred[i*2+k] * h[k], 8);
            pht[i] = clamp32(acc);
         end
         s = r * 256;
         for (int k = 0; k < 2; k++) s += floor_shift(h[k] * pht[k], 8);
         s = clamp32(s);
         for (int i = 0; i < 2; i++) kg[i] = (s == 0) ? 0 : clamp32((pht[i] * 65536) / s);
         fault = (s == 0);
         hx = 0;
         for (int k = 0; k < 2; k++) hx += floor_shift(h[k] * xpred[k], 8);
         hx = clamp32(hx);
         y = clamp32(z - hx);
         for (int i = 0; i < 2; i++) x[i] = clamp32(xpred[i] + floor_shift(kg[i] * y, 16));
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
               a[i*2+j] = clamp32((i == j ? 65536 : 0) - floor_shift(kg[i] * h[j], 8));
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
               acc = 0;
               for (int k = 0; k < 2; k++) acc += floor_shift(a[i*2+k] * ppred[k*2+j], 16);
               m[i*2+j] = clamp32(acc);
            end
         for (int i = 0; i < 2; i++) kr[i] = clamp32(floor_shift(kg[i] * r, 8));
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++) begin
               acc = floor_shift(kr[i] * kg[j], 16);
               for (int k = 0; k < 2; k++) acc += floor_shift(m[i*2+k] * a[j*2+k], 16);
               p[i*2+j] = clamp32(acc);
            end
      end
      for (int i = 0; i < 2; i++) begin
         acc = 0;
         for (int k = 0; k < 2; k++) acc += floor_shift(q88_entry(mdl_f, i*2+k) * x[k], 8);
         xpred[i] = clamp32(acc);
      end
      fpft_model(p, qnoise, ppred);
      res.estimate_first  = x[0][31:0];
      res.estimate_second = x[1][31:0];
      res.variance_first  = p[0][31:0];
      res.variance_second = p[3][31:0];
      res.gain_fault      = fault;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // driver
   logic req_taken;
   always @(posedge clock) req_taken <= req_valid && !req_stall && !reset;

   always @(negedge clock) begin
      kfs_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_valid && req_taken) void'(pending_req.pop_front());
         if (driving && pending_req.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_req[0];
            req_data  <= nxt;
            req_valid <= 1'b1;
            expected_rsp.push_back(filter_step(nxt));
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      kfs_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result", '0, '0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.estimate_first !== want.estimate_first)
               report_mismatch("estimate_first", rsp_data.estimate_first, want.estimate_first);
            if (rsp_data.estimate_second !== want.estimate_second)
               report_mismatch("estimate_second", rsp_data.estimate_second,
                               want.estimate_second);
            if (rsp_data.variance_first !== want.variance_first)
               report_mismatch("variance_first", rsp_data.variance_first, want.variance_first);
            if (rsp_data.variance_second !== want.variance_second)
               report_mismatch("variance_second", rsp_data.variance_second,
                               want.variance_second);
            if (rsp_data.gain_fault !== want.gain_fault)
               report_mismatch("gain_fault", {31'd0, rsp_data.gain_fault},
                               {31'd0, want.gain_fault});
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [63:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_TRANSITION:  mdl_f  = val;
         CSR_MEASUREMENT: mdl_h  = val[31:0];
         CSR_PROC_NOISE:  mdl_qa = val;
         CSR_MEAS_NOISE:  mdl_r  = val[15:0];
         CSR_INIT_STATE:  mdl_x0 = val;
         default:         mdl_p0 = val;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // wait for all queued transfers and results, then settle
   task automatic drain();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic push_item(logic func, logic [31:0] meas);
      kfs_req_type it;
      it.func = func;
      it.measurement = meas;
      pending_req.push_back(it);
   endtask

   function automatic logic [15:0] small_q88();
      logic signed [15:0] v;
      v = 16'($signed($urandom_range(0, 640)) - 320);
      return v;
   endfunction

   task automatic random_config(bit extreme);
      if (extreme) begin
         write_csr(CSR_TRANSITION, {$urandom, $urandom});
         write_csr(CSR_MEASUREMENT, 64'($urandom));
         write_csr(CSR_PROC_NOISE, {$urandom, $urandom});
         write_csr(CSR_MEAS_NOISE, 64'($urandom_range(0, 65535)));
         write_csr(CSR_INIT_STATE, {$urandom, $urandom});
         write_csr(CSR_INIT_COV, {$urandom, $urandom});
      end else begin
         write_csr(CSR_TRANSITION, {small_q88(), small_q88(), small_q88(), small_q88()});
         write_csr(CSR_MEASUREMENT, {32'd0, small_q88(), small_q88()});
         write_csr(CSR_PROC_NOISE, {small_q88(), small_q88(), small_q88(), small_q88()});
         write_csr(CSR_MEAS_NOISE, 64'($urandom_range(0, 1024)));
         write_csr(CSR_INIT_STATE, {$urandom, $urandom} >> $urandom_range(0, 12));
         write_csr(CSR_INIT_COV, {small_q88(), small_q88(), small_q88(), small_q88()});
      end
   endtask

   task automatic random_items(int n);
      for (int i = 0; i < n; i++)
         push_item(($urandom_range(99) < 12) ? FUNC_RESTART : FUNC_UPDATE,
                   ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom) >>> 12));
   endtask

   initial begin
      mdl_f = 64'h0100_0000_0000_0100;
      mdl_h = 32'h0000_0100;
      mdl_qa = '0;
      mdl_r = 16'h0100;
      mdl_x0 = '0;
      mdl_p0 = 64'h0100_0000_0000_0100;
      for (int i = 0; i < 2; i++) xpred[i] = 0;
      for (int i = 0; i < 4; i++) begin
         ppred[i] = 0;
         qnoise[i] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: update on reset state, restart, extremes
      driving = 1'b1;
      push_item(FUNC_UPDATE, 32'h0001_0000);
      push_item(FUNC_UPDATE, 32'h7FFF_FFFF);
      push_item(FUNC_RESTART, 32'h8000_0000);
      push_item(FUNC_UPDATE, 32'h8000_0000);
      push_item(FUNC_UPDATE, 32'h7FFF_FFFF);
      push_item(FUNC_UPDATE, 32'hFFFF_FFFF);
      push_item(FUNC_UPDATE, 32'h0000_0000);
      drain();
      write_csr(CSR_MEAS_NOISE, 64'd0);
      write_csr(CSR_INIT_COV, 64'd0);
      push_item(FUNC_RESTART, 32'd0);
      push_item(FUNC_UPDATE, 32'h0123_4567);
      drain();
      write_csr(CSR_TRANSITION, 64'h7FFF_8000_8000_7FFF);
      write_csr(CSR_MEASUREMENT, 64'hFFFF_FFFF);
      write_csr(CSR_PROC_NOISE, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_MEAS_NOISE, 64'hFFFF);
      write_csr(CSR_INIT_STATE, 64'h8000_0000_7FFF_FFFF);
      write_csr(CSR_INIT_COV, 64'h7FFF_8000_8000_7FFF);
      push_item(FUNC_RESTART, 32'd0);
      push_item(FUNC_UPDATE, 32'h8000_0000);
      push_item(FUNC_UPDATE, 32'h7FFF_FFFF);
      push_item(FUNC_RESTART, 32'hFFFF_FFFF);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         random_config(ph == 3 || ph == 6);
         push_item(FUNC_RESTART, $urandom);
         random_items(45);
         while (pending_req.size() > 20) @(posedge clock);
         // hold the sender until every result is back
         driving = 1'b0;
         while (req_valid || expected_rsp.size() != 0) @(posedge clock);
         driving = 1'b1;
         random_items(45);
         drain();
      end

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
hdl/kfs_pkg.sv
hdl/kfs_regfile.sv
hdl/kfs_mac.sv
hdl/kfs_divider.sv
hdl/kalman_filter_step.sv
tb/kalman_filter_step_tb.sv
